/* rtl/gru_pkg.sv */
// Shared types and constants of the gauge reading unit converter.
// Depends on nothing; every other file of the block uses it.
`default_nettype none
package gru_pkg;

   localparam int NUM_W = 29;   // divider dividend and quotient width
   localparam int DEN_W = 26;   // divider divisor and remainder width
   localparam int VAL_W = 30;   // converted value width
   localparam int RAW_W = 16;

   typedef enum logic [3:0] {
      KIND_VOLT  = 4'd0,
      KIND_CURR  = 4'd1,
      KIND_CHG   = 4'd2,
      KIND_SOC   = 4'd3,
      KIND_REM   = 4'd4,
      KIND_FULL  = 4'd5,
      KIND_DCAP  = 4'd6,
      KIND_TIME  = 4'd7,
      KIND_TEMP  = 4'd8,
      KIND_RAW   = 4'd9,
      KIND_DVOLT = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RSENSE = 2'd0,
      CSR_DCAP   = 2'd1,
      CSR_DVOLT  = 2'd2
   } csr_index_type;

   // Per-item data that rides alongside the divider
   typedef struct packed {
      kind_type                 kind;
      logic                     neg;
      logic signed [VAL_W-1:0]  value;
      logic                     status;
   } side_type;

   typedef struct packed {
      logic              valid;
      side_type          side;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
      logic [DEN_W-1:0]  rem;
      logic [NUM_W-1:0]  quo;
   } div_stage_type;

   // Capacity limits derived from the design capacity register
   typedef struct packed {
      logic [15:0] dcap;
      logic [25:0] dcap_uah;
      logic [26:0] rem_limit;
      logic [26:0] full_low;
      logic [26:0] full_high;
   } limits_type;

endpackage
`default_nettype wire

/* rtl/gru_channels.sv */
// Handshake channel interfaces: request, response and register write.
// Depends on gru_pkg for the payload widths.
`default_nettype none
interface gru_req_if;
   logic                      valid;
   logic                      ready;
   logic [3:0]                kind;
   logic [gru_pkg::RAW_W-1:0] raw;
   modport source (output valid, kind, raw, input ready);
   modport sink (input valid, kind, raw, output ready);
endinterface

interface gru_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [gru_pkg::VAL_W-1:0] value;
   logic                             status;
   modport source (output valid, value, status, input ready);
   modport sink (input valid, value, status, output ready);
endinterface

interface gru_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/gru_front.sv */
// Input stage: decodes the kind, forms divider operands and direct results.
// Depends on gru_pkg.
`default_nettype none
module gru_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [3:0]                 in_kind,
   input  wire logic [gru_pkg::RAW_W-1:0]  in_raw,
   input  wire logic [15:0]                rsense,
   output gru_pkg::div_stage_type          stage_out
);
   import gru_pkg::*;

   div_stage_type           stage_ff, stage_in;
   kind_type                kind;
   logic [15:0]             rs_eff;
   logic                    neg;
   logic [15:0]             mag;
   logic [NUM_W-1:0]        cur_num, cap_num;
   logic [DEN_W-1:0]        den10, den1, den1000;
   logic [25:0]             volt_prod;
   logic [17:0]             time_prod;
   logic signed [20:0]      temp_x, temp_adj, temp_q;
   logic [7:0]              soc;

   // Operand preparation
   always_comb begin
      kind      = kind_type'(in_kind);
      rs_eff    = (rsense == 16'd0) ? 16'd10 : rsense;
      neg       = in_raw[15];
      mag       = neg ? (~in_raw + 16'd1) : in_raw;
      cur_num   = NUM_W'(mag) * NUM_W'(15625);
      cap_num   = NUM_W'(in_raw) * NUM_W'(5000);
      den1      = DEN_W'(rs_eff);
      den10     = DEN_W'(rs_eff) * DEN_W'(10);
      den1000   = DEN_W'(rs_eff) * DEN_W'(1000);
      volt_prod = 26'(in_raw) * 26'd625;
      time_prod = 18'(in_raw) * 18'd3;
      temp_x    = 21'($signed(in_raw)) * 21'sd10;
      // signed divide by 256 truncating toward zero
      temp_adj  = temp_x[20] ? (temp_x + 21'sd255) : temp_x;
      temp_q    = temp_adj >>> 8;
      soc       = (in_raw[15:8] > 8'd100) ? 8'd100 : in_raw[15:8];
   end

   // Select per kind
   always_comb begin
      stage_in             = '0;
      stage_in.valid       = in_valid;
      stage_in.side.kind   = kind;
      stage_in.side.neg    = neg;
      stage_in.num         = cap_num;
      stage_in.den         = den1;
      case (kind)
         KIND_VOLT:  stage_in.side.value = VAL_W'(volt_prod >> 3);
         KIND_CURR,
         KIND_CHG:   begin
            stage_in.num = cur_num;
            stage_in.den = den10;
         end
         KIND_SOC:   stage_in.side.value = VAL_W'(soc);
         KIND_REM,
         KIND_FULL:  stage_in.den = den1;
         KIND_DCAP:  stage_in.den = den1000;
         KIND_TIME:  stage_in.side.value = VAL_W'(time_prod >> 5);
         KIND_TEMP:  stage_in.side.value = VAL_W'(temp_q) + VAL_W'(2732);
         KIND_RAW:   stage_in.side.value = VAL_W'(in_raw);
         KIND_DVOLT: stage_in.side.value = '0;
         default:    stage_in.side.status = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;
endmodule
`default_nettype wire

/* rtl/gru_divider.sv */
// Restoring divider, one quotient bit per register stage.
// Depends on gru_pkg.
`default_nettype none
module gru_divider (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire gru_pkg::div_stage_type  stage_in,
   output gru_pkg::div_stage_type       stage_out
);
   import gru_pkg::*;

   div_stage_type stage_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      div_stage_type     prev, nxt_in;
      logic [DEN_W:0]    trial, diff;
      logic              ge;

      // Shift in the next dividend bit, subtract when it fits
      always_comb begin
         prev   = (i == 0) ? stage_in : stage_ff[(i == 0) ? 0 : i - 1];
         trial  = {prev.rem, prev.num[NUM_W-1]};
         diff   = trial - {1'b0, prev.den};
         ge     = (trial >= {1'b0, prev.den});
         nxt_in = prev;
         nxt_in.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         nxt_in.num = {prev.num[NUM_W-2:0], 1'b0};
         nxt_in.quo = {prev.quo[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[i].valid <= 1'b0;
         end else if (en) begin
            stage_ff[i] <= nxt_in;
         end
      end
   end

   assign stage_out = stage_ff[NUM_W-1];
endmodule
`default_nettype wire

/* rtl/gru_back.sv */
// Output stage: sign, clamps and capacity checks, then the result register.
// Depends on gru_pkg.
`default_nettype none
module gru_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire gru_pkg::div_stage_type        stage_in,
   input  wire gru_pkg::limits_type           limits,
   input  wire logic [15:0]                   dvolt,
   output logic                               out_valid,
   output logic signed [gru_pkg::VAL_W-1:0]   out_value,
   output logic                               out_status
);
   import gru_pkg::*;

   logic                    valid_ff;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic                    status_ff;
   logic [NUM_W-1:0]        c;
   logic signed [VAL_W-1:0] cval, duah;
   logic                    dnz;

   // Result selection
   always_comb begin
      c     = stage_in.quo;
      cval  = VAL_W'(c);
      duah  = VAL_W'(limits.dcap_uah);
      dnz   = (limits.dcap != 16'd0);
      value_in = stage_in.side.value;
      case (stage_in.side.kind)
         KIND_CURR:  value_in = stage_in.side.neg ? -cval : cval;
         KIND_CHG:   value_in = stage_in.side.neg ? '0 : cval;
         KIND_REM:   value_in = (dnz && (c > NUM_W'(limits.rem_limit))) ? duah : cval;
         KIND_FULL:  value_in = (dnz && ((c < NUM_W'(1000)) ||
                                         (c < NUM_W'(limits.full_low)) ||
                                         (c >= NUM_W'(limits.full_high)))) ? duah : cval;
         KIND_DCAP:  value_in = dnz ? VAL_W'(limits.dcap) : cval;
         KIND_DVOLT: value_in = VAL_W'(dvolt);
         default:    value_in = stage_in.side.value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff  <= stage_in.valid;
         value_ff  <= value_in;
         status_ff <= stage_in.side.status;
      end
   end

   assign out_valid  = valid_ff;
   assign out_value  = value_ff;
   assign out_status = status_ff;
endmodule
`default_nettype wire

/* rtl/gauge_reading_unit_converter.sv */
// Top level of the gauge reading unit converter: registers and pipeline.
// Depends on gru_pkg, gru_channels, gru_front, gru_divider and gru_back.
//
//   channel  | role  | payload
//   ---------+-------+------------------------------
//   req_bus  | sink  | kind[3:0], raw[15:0]
//   rsp_bus  | source| value[29:0] signed, status
//   csr_bus  | sink  | index[1:0], data[15:0]
//
// Accepts one request per cycle unless rsp_bus stalls. It has one operand
// stage, 29 divider stages (one quotient bit each) and the result register.
// Synchronous active-high reset clears valid bits and loads register defaults.
// A stalled response freezes the whole pipeline; req_bus.ready follows it.
`default_nettype none
module gauge_reading_unit_converter (
   input  wire logic  clock,
   input  wire logic  reset,
   gru_req_if.sink    req_bus,
   gru_rsp_if.source  rsp_bus,
   gru_csr_if.sink    csr_bus
);
   import gru_pkg::*;

   logic [15:0]    rsense_ff, dcap_ff, dvolt_ff;
   limits_type     limits_ff, limits_in;
   logic           en;
   logic           rsp_valid;
   div_stage_type  front_stage, div_stage;

   assign en            = !rsp_valid || rsp_bus.ready;
   assign req_bus.ready = en;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = rsp_valid;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsense_ff <= 16'd10;
         dcap_ff   <= 16'd0;
         dvolt_ff  <= 16'd3700;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_RSENSE: rsense_ff <= csr_bus.data;
            CSR_DCAP:   dcap_ff   <= csr_bus.data;
            CSR_DVOLT:  dvolt_ff  <= csr_bus.data;
            default:    ;
         endcase
      end
   end

   // Capacity limits, used only at the end of the pipeline
   always_comb begin
      limits_in.dcap      = dcap_ff;
      limits_in.dcap_uah  = 26'(dcap_ff) * 26'd1000;
      limits_in.rem_limit = 27'(limits_in.dcap_uah) + 27'(limits_in.dcap_uah >> 2);
      limits_in.full_low  = 27'((18'(dcap_ff) * 18'd3) >> 2) * 27'd1000;
      limits_in.full_high = ((27'(dcap_ff) << 1) + 27'd1) * 27'd1000;
   end

   always_ff @(posedge clock) begin
      limits_ff <= limits_in;
   end

   gru_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_kind   (req_bus.kind),
      .in_raw    (req_bus.raw),
      .rsense    (rsense_ff),
      .stage_out (front_stage)
   );

   gru_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .stage_in  (front_stage),
      .stage_out (div_stage)
   );

   gru_back u_back (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .stage_in   (div_stage),
      .limits     (limits_ff),
      .dvolt      (dvolt_ff),
      .out_valid  (rsp_valid),
      .out_value  (rsp_bus.value),
      .out_status (rsp_bus.status)
   );
endmodule
`default_nettype wire

/* verif/gauge_reading_unit_converter_tb.sv */
// Self-checking bench for the gauge reading unit converter: random and directed
// conversions, register settings between phases, stalls on both channels.
// Depends on gru_pkg, gru_channels and the converter RTL.
`default_nettype none
module gauge_reading_unit_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gru_pkg::*;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] raw;
   } reading_type;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             status;
   } converted_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gru_req_if req_bus ();
   gru_rsp_if rsp_bus ();
   gru_csr_if csr_bus ();

   gauge_reading_unit_converter dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the registers
   logic [15:0] rsense_q = 16'd10;
   logic [15:0] dcap_q = 16'd0;
   logic [15:0] dvolt_q = 16'd3700;

   reading_type   pending_readings[$];
   converted_type expected_values[$];
   int errors = 0;
   int accepted_in = 0;
   int accepted_out = 0;
   bit idle_enable = 1'b1;
   int long_hold = 0;
   int idle_cycles = 0;

   function automatic converted_type convert_reading(reading_type r);
      longint rs, v, c, m, d, d_uah, sraw;
      converted_type res;
      rs = (rsense_q == 0) ? 10 : rsense_q;
      d = dcap_q;
      d_uah = d * 1000;
      sraw = $signed(r.raw);
      c = (longint'(r.raw) * 5000) / rs;
      v = 0;
      res.status = 1'b0;
      case (r.kind)
         KIND_VOLT: v = (longint'(r.raw) * 78125) / 1000;
         KIND_CURR, KIND_CHG: begin
            v = (sraw * 15625) / (10 * rs);
            if (r.kind == KIND_CHG && v < 0) v = 0;
         end
         KIND_SOC: begin
            v = r.raw / 256;
            if (v > 100) v = 100;
         end
         KIND_REM: begin
            v = c;
            if (d != 0 && v > d_uah + d_uah / 4) v = d_uah;
         end
         KIND_FULL: begin
            m = c / 1000;
            if (d != 0 && (m == 0 || m < (d * 3) / 4 || m > d * 2)) v = d_uah;
            else v = c;
         end
         KIND_DCAP: v = (d != 0) ? d : c / 1000;
         KIND_TIME: v = (longint'(r.raw) * 5625) / 60000;
         KIND_TEMP: v = (sraw * 10) / 256 + 2732;
         KIND_RAW: v = r.raw;
         KIND_DVOLT: v = dvolt_q;
         default: res.status = 1'b1;
      endcase
      res.value = v[VAL_W-1:0];
      return res;
   endfunction

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_values.push_back(convert_reading({req_bus.kind, req_bus.raw}));
            accepted_in++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(1, 8) - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_readings.size() > 0) begin
               reading_type r;
               r = pending_readings.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.kind <= r.kind;
               req_bus.raw <= r.raw;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready control
   int rsp_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            accepted_out++;
            if (expected_values.size() == 0) begin
               errors++;
               $display("%0t: unexpected result value=%0d status=%0d", $realtime,
                        rsp_bus.value, rsp_bus.status);
            end else begin
               converted_type e;
               e = expected_values.pop_front();
               if (rsp_bus.value !== e.value) begin
                  errors++;
                  $display("%0t: value expected %0d actual %0d", $realtime,
                           $signed(e.value), rsp_bus.value);
               end
               if (rsp_bus.status !== e.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           e.status, rsp_bus.status);
               end
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            rsp_gap = $urandom_range(1, 8) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("** gauge_reading_unit_converter: FAILED **");
         $finish;
      end
   end

   task automatic write_register(csr_index_type idx, logic [15:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_RSENSE: rsense_q = data;
         CSR_DCAP: dcap_q = data;
         default: dvolt_q = data;
      endcase
   endtask

   // wait until every queued reading has gone and every result has come back
   task automatic drain_pipeline();
      while (!(pending_readings.size() == 0 && !req_bus.valid
               && expected_values.size() == 0))
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic reading_type random_reading();
      reading_type r;
      r.kind = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                            : 4'($urandom_range(0, 10));
      case ($urandom_range(0, 5))
         0: r.raw = 16'hFFFF;
         1: r.raw = 16'h0000;
         2: r.raw = 16'($urandom_range(0, 255));
         3: r.raw = {1'b1, 15'($urandom)};
         default: r.raw = 16'($urandom);
      endcase
      return r;
   endfunction

   initial begin
      static logic [15:0] rs_set[5] = '{16'd0, 16'd1, 16'd10, 16'd65535, 16'd3};
      static logic [15:0] dc_set[5] = '{16'd0, 16'd65535, 16'd3000, 16'd1, 16'd0};
      static logic [15:0] dv_set[5] = '{16'd0, 16'd65535, 16'd3700, 16'd4200, 16'd1};
      req_bus.valid = 1'b0;
      req_bus.kind = '0;
      req_bus.raw = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_RSENSE;
      csr_bus.data = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: every kind at the raw extremes under reset settings
      for (int k = 0; k < 12; k++) begin
         pending_readings.push_back({4'(k), 16'h0000});
         pending_readings.push_back({4'(k), 16'hFFFF});
      end
      pending_readings.push_back({4'd15, 16'h8000});
      drain_pipeline();

      // random phases under several register settings
      for (int p = 0; p < 5; p++) begin
         write_register(CSR_RSENSE, rs_set[p]);
         write_register(CSR_DCAP, dc_set[p]);
         write_register(CSR_DVOLT, dv_set[p]);
         if (p == 4) idle_enable = 1'b0;
         for (int i = 0; i < 360; i++) pending_readings.push_back(random_reading());
         if (p == 1) begin
            wait (accepted_in > 0);
            long_hold = 200;
         end
         drain_pipeline();
      end

      $display("Covered %0d conversions over all kinds, five register settings,",
               accepted_out);
      $display("random stalls on both channels and a long back-pressure stretch.");
      if (errors == 0 && expected_values.size() == 0)
         $display("** gauge_reading_unit_converter: PASSED **");
      else
         $display("** gauge_reading_unit_converter: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
